// ===== hdl/stam_pkg.sv =====
// ----------------------------------------------------------------------------
// stam_pkg: shared types and constants of the stepped actuator tracking monitor
// Holds the event, decision and fault codes, the configuration register
// indexes and reset values, and the structs passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stam_pkg;

  // Field widths
  localparam int unsigned CmdW   = 10;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DriveW = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Largest legal command, tenths of a percent
  localparam logic [CmdW-1:0] CmdLimit = CmdW'(1000);

  // Event codes
  typedef enum logic [1:0] {
    REQ_INIT       = 2'd0,
    REQ_FORCE_WARM = 2'd1,
    REQ_DECISION   = 2'd2,
    REQ_FEEDBACK   = 2'd3
  } req_e;

  // Valve decision codes
  typedef enum logic [1:0] {
    DEC_HOLD    = 2'd0,
    DEC_WARMER  = 2'd1,
    DEC_COOLER  = 2'd2,
    DEC_INVALID = 2'd3
  } dec_e;

  // Fault codes
  typedef enum logic [1:0] {
    FAULT_CLEAR    = 2'd0,
    FAULT_CONFIG   = 2'd1,
    FAULT_FEEDBACK = 2'd2,
    FAULT_TRACKING = 2'd3
  } fault_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_COMMAND  = 3'd0,
    CFG_MAX_COMMAND  = 3'd1,
    CFG_STEP_SIZE    = 3'd2,
    CFG_TRACK_TOL    = 3'd3,
    CFG_SETTLE_TIME  = 3'd4,
    CFG_WARM_IS_HIGH = 3'd5,
    CFG_FB_REQUIRED  = 3'd6
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [CmdW-1:0]  MinCommandRst = CmdW'(0);
  localparam logic [CmdW-1:0]  MaxCommandRst = CmdW'(1000);
  localparam logic [CmdW-1:0]  StepSizeRst   = CmdW'(10);
  localparam logic [CmdW-1:0]  TrackTolRst   = CmdW'(50);
  localparam logic [TimeW-1:0] SettleTimeRst = TimeW'(5000);

  typedef struct packed {
    logic [CmdW-1:0]  min_command;
    logic [CmdW-1:0]  max_command;
    logic [CmdW-1:0]  step_size;
    logic [CmdW-1:0]  track_tolerance;
    logic [TimeW-1:0] settle_time_ms;
    logic             warm_is_high;
    logic             feedback_required;
  } cfg_t;

  typedef struct packed {
    req_e             req_type;
    logic [TimeW-1:0] time_ms;
    logic [CmdW-1:0]  start_command;
    dec_e             valve_decision;
    logic [CmdW-1:0]  feedback_value;
    logic             feedback_present;
  } item_t;

  // Tracking flag is implied by fault == FAULT_TRACKING
  typedef struct packed {
    logic             initialized;
    logic [CmdW-1:0]  commanded;
    logic             feedback_usable;
    fault_e           fault;
    logic [TimeW-1:0] last_change_time;
  } state_t;

  typedef struct packed {
    logic [CmdW-1:0]   command_now;
    logic [DriveW-1:0] drive_millivolts;
    fault_e            fault_code;
    logic              feedback_ok;
    logic              ready_res;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/stam_step.sv =====
// ----------------------------------------------------------------------------
// stam_step: event evaluation
// Combinational next-state and result logic for one event, given the current
// state, the configuration and the registered input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module stam_step (
  input  var stam_pkg::state_t  state_i,
  input  var stam_pkg::cfg_t    cfg_i,
  input  var stam_pkg::item_t   item_i,
  output var stam_pkg::state_t  state_o,
  output var stam_pkg::result_t result_o
);

  logic                          cfg_ok;
  logic                          step_up;
  logic signed [stam_pkg::CmdW+1:0] step_raw;
  logic [stam_pkg::CmdW-1:0]     step_cmd;
  logic [stam_pkg::CmdW-1:0]     start_cmd;
  logic                          fb_usable;
  logic [stam_pkg::CmdW-1:0]     fb_diff;
  logic [stam_pkg::TimeW-1:0]    elapsed;
  stam_pkg::fault_e              fb_missing_fault;
  stam_pkg::state_t              nxt;

  // Check the configuration limits
  always_comb begin
    cfg_ok = (cfg_i.min_command < cfg_i.max_command) &&
             (cfg_i.max_command <= stam_pkg::CmdLimit) &&
             (cfg_i.step_size != '0) &&
             (cfg_i.step_size <= (cfg_i.max_command - cfg_i.min_command)) &&
             (cfg_i.track_tolerance <= stam_pkg::CmdLimit);
  end

  // Clamp the start command to the limits
  always_comb begin
    if (item_i.start_command < cfg_i.min_command) begin
      start_cmd = cfg_i.min_command;
    end else if (item_i.start_command > cfg_i.max_command) begin
      start_cmd = cfg_i.max_command;
    end else begin
      start_cmd = item_i.start_command;
    end
  end

  // Step the command warmer or cooler, then clamp
  always_comb begin
    step_up = (item_i.valve_decision == stam_pkg::DEC_WARMER) ? cfg_i.warm_is_high
                                                              : !cfg_i.warm_is_high;
    if (item_i.valve_decision == stam_pkg::DEC_HOLD) begin
      step_raw = $signed({2'b00, state_i.commanded});
    end else if (step_up) begin
      step_raw = $signed({2'b00, state_i.commanded}) + $signed({2'b00, cfg_i.step_size});
    end else begin
      step_raw = $signed({2'b00, state_i.commanded}) - $signed({2'b00, cfg_i.step_size});
    end
    if (step_raw < $signed({2'b00, cfg_i.min_command})) begin
      step_cmd = cfg_i.min_command;
    end else if (step_raw > $signed({2'b00, cfg_i.max_command})) begin
      step_cmd = cfg_i.max_command;
    end else begin
      step_cmd = step_raw[stam_pkg::CmdW-1:0];
    end
  end

  // Qualify the feedback sample and measure the tracking error
  always_comb begin
    fb_usable = item_i.feedback_present &&
                (item_i.feedback_value >= cfg_i.min_command) &&
                (item_i.feedback_value <= cfg_i.max_command);
    fb_diff = (item_i.feedback_value > state_i.commanded)
            ? (item_i.feedback_value - state_i.commanded)
            : (state_i.commanded - item_i.feedback_value);
    elapsed = item_i.time_ms - state_i.last_change_time;
    fb_missing_fault = cfg_i.feedback_required ? stam_pkg::FAULT_FEEDBACK
                                               : stam_pkg::FAULT_CLEAR;
  end

  // Apply the event to the state
  always_comb begin
    nxt = state_i;
    if (item_i.req_type == stam_pkg::REQ_INIT) begin
      nxt.initialized      = 1'b1;
      nxt.feedback_usable  = 1'b0;
      nxt.last_change_time = item_i.time_ms;
      if (!cfg_ok) begin
        nxt.commanded = '0;
        nxt.fault     = stam_pkg::FAULT_CONFIG;
      end else begin
        nxt.commanded = start_cmd;
        nxt.fault     = fb_missing_fault;
      end
    end else if (state_i.initialized) begin
      if (!cfg_ok || ((item_i.req_type == stam_pkg::REQ_DECISION) &&
                      (item_i.valve_decision == stam_pkg::DEC_INVALID))) begin
        nxt.fault = stam_pkg::FAULT_CONFIG;
      end else begin
        case (item_i.req_type)
          stam_pkg::REQ_FORCE_WARM: begin
            nxt.commanded = cfg_i.warm_is_high ? cfg_i.max_command : cfg_i.min_command;
            nxt.last_change_time = item_i.time_ms;
            nxt.fault = state_i.feedback_usable ? stam_pkg::FAULT_CLEAR : fb_missing_fault;
          end
          stam_pkg::REQ_DECISION: begin
            if (step_cmd != state_i.commanded) begin
              nxt.commanded        = step_cmd;
              nxt.last_change_time = item_i.time_ms;
            end
            if (state_i.fault == stam_pkg::FAULT_TRACKING) begin
              nxt.fault = stam_pkg::FAULT_TRACKING;
            end else if (!state_i.feedback_usable) begin
              nxt.fault = fb_missing_fault;
            end else begin
              nxt.fault = stam_pkg::FAULT_CLEAR;
            end
          end
          stam_pkg::REQ_FEEDBACK: begin
            nxt.feedback_usable = fb_usable;
            if (!fb_usable) begin
              nxt.fault = fb_missing_fault;
            end else if ((elapsed >= cfg_i.settle_time_ms) &&
                         (fb_diff > cfg_i.track_tolerance)) begin
              nxt.fault = stam_pkg::FAULT_TRACKING;
            end else begin
              nxt.fault = stam_pkg::FAULT_CLEAR;
            end
          end
          default: begin
            nxt = state_i;
          end
        endcase
      end
    end
  end

  // Form the result from the updated state; drive = command * 10
  always_comb begin
    state_o = nxt;
    result_o.command_now      = nxt.commanded;
    result_o.drive_millivolts = ({4'b0000, nxt.commanded} << 3) +
                                ({4'b0000, nxt.commanded} << 1);
    result_o.fault_code       = nxt.fault;
    result_o.feedback_ok      = nxt.feedback_usable;
    result_o.ready_res        = nxt.initialized;
  end

endmodule

`default_nettype wire

// ===== hdl/stepped_actuator_tracking_monitor_top.sv =====
// ----------------------------------------------------------------------------
// stepped_actuator_tracking_monitor_top: valve command and tracking monitor
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per transaction:
//   initialize, force warm, valve decision or feedback sample. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result per event: command,
//   drive in millivolts, fault code, feedback status and ready flag.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i; the user must write them only while no transaction is in
//   flight, as the block itself does not enforce it; unknown indexes are
//   dropped. An accepted event is held in the input register, evaluated
//   against the state registers, and its result is loaded into the result
//   register once that is free. Throughput is one transaction per cycle
//   while the output is not stalled; the state feedback loop through
//   stam_step has no register but the state registers. Reset clears the
//   state (block not initialized) and loads the default configuration.
//   While the receiver stalls, the result register holds, the input register
//   fills, and then in_stall_o is raised until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module stepped_actuator_tracking_monitor_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [stam_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [stam_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Input channel
  input  wire logic                            in_valid_i,
  output var  logic                            in_stall_o,
  input  wire logic [1:0]                      req_type_i,
  input  wire logic [stam_pkg::TimeW-1:0]      time_ms_i,
  input  wire logic [stam_pkg::CmdW-1:0]       start_command_i,
  input  wire logic [1:0]                      valve_decision_i,
  input  wire logic [stam_pkg::CmdW-1:0]       feedback_value_i,
  input  wire logic                            feedback_present_i,
  // Output channel
  output var  logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output var  logic [stam_pkg::CmdW-1:0]       command_now_o,
  output var  logic [stam_pkg::DriveW-1:0]     drive_millivolts_o,
  output var  logic [1:0]                      fault_code_o,
  output var  logic                            feedback_ok_o,
  output var  logic                            ready_res_o
);

  stam_pkg::cfg_t    cfg_q;
  stam_pkg::item_t   item_q;
  logic              item_valid_q;
  stam_pkg::state_t  state_q;
  stam_pkg::state_t  state_d;
  stam_pkg::result_t res_d;
  stam_pkg::result_t res_q;
  logic              res_valid_q;
  logic              res_load;
  logic              in_accept;

  // Move the held transaction into the result register when it is free
  assign res_load   = item_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !res_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_command       <= stam_pkg::MinCommandRst;
      cfg_q.max_command       <= stam_pkg::MaxCommandRst;
      cfg_q.step_size         <= stam_pkg::StepSizeRst;
      cfg_q.track_tolerance   <= stam_pkg::TrackTolRst;
      cfg_q.settle_time_ms    <= stam_pkg::SettleTimeRst;
      cfg_q.warm_is_high      <= 1'b1;
      cfg_q.feedback_required <= 1'b0;
    end else if (cfg_we_i) begin
      case (stam_pkg::cfg_idx_e'(cfg_idx_i))
        stam_pkg::CFG_MIN_COMMAND:  cfg_q.min_command     <= cfg_wdata_i[stam_pkg::CmdW-1:0];
        stam_pkg::CFG_MAX_COMMAND:  cfg_q.max_command     <= cfg_wdata_i[stam_pkg::CmdW-1:0];
        stam_pkg::CFG_STEP_SIZE:    cfg_q.step_size       <= cfg_wdata_i[stam_pkg::CmdW-1:0];
        stam_pkg::CFG_TRACK_TOL:    cfg_q.track_tolerance <= cfg_wdata_i[stam_pkg::CmdW-1:0];
        stam_pkg::CFG_SETTLE_TIME:  cfg_q.settle_time_ms  <= cfg_wdata_i[stam_pkg::TimeW-1:0];
        stam_pkg::CFG_WARM_IS_HIGH: cfg_q.warm_is_high    <= cfg_wdata_i[0];
        stam_pkg::CFG_FB_REQUIRED:  cfg_q.feedback_required <= cfg_wdata_i[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Hold the accepted transaction in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_accept) begin
      item_valid_q <= 1'b1;
    end else if (res_load) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.req_type         <= stam_pkg::req_e'(req_type_i);
      item_q.time_ms          <= time_ms_i;
      item_q.start_command    <= start_command_i;
      item_q.valve_decision   <= stam_pkg::dec_e'(valve_decision_i);
      item_q.feedback_value   <= feedback_value_i;
      item_q.feedback_present <= feedback_present_i;
    end
  end

  // Evaluate the event
  stam_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Advance the state together with the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.initialized      <= 1'b0;
      state_q.commanded        <= '0;
      state_q.feedback_usable  <= 1'b0;
      state_q.fault            <= stam_pkg::FAULT_CLEAR;
      state_q.last_change_time <= '0;
      res_valid_q              <= 1'b0;
    end else begin
      if (res_load) begin
        state_q     <= state_d;
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = res_valid_q;
  assign command_now_o      = res_q.command_now;
  assign drive_millivolts_o = res_q.drive_millivolts;
  assign fault_code_o       = res_q.fault_code;
  assign feedback_ok_o      = res_q.feedback_ok;
  assign ready_res_o        = res_q.ready_res;

endmodule

`default_nettype wire

// ===== dv/tb_stepped_actuator_tracking_monitor_top.sv =====
// ----------------------------------------------------------------------------
// tb_stepped_actuator_tracking_monitor_top: valve command monitor testbench
// Offers initialize, force-warm, decision and feedback transactions to the
// block under several register settings, valid and invalid. A predictor
// computes each expected result, and a monitor compares the results in order.
// Both channels idle and stall at random, and one long output stall backs
// the block up.
// ----------------------------------------------------------------------------
module tb_stepped_actuator_tracking_monitor_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [stam_pkg::CfgIdxW-1:0] CfgIdxUnused = 3'd7;
  localparam int unsigned        MvPerTenth   = 10;
  localparam int unsigned        IdlePct      = 13;
  localparam int unsigned        HoldoffAt    = 200;
  localparam int unsigned        HoldoffLen   = 60;
  localparam int unsigned        DrainLimit   = 2000;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // Block inputs, known from time zero
  logic                          cfg_we    = 1'b0;
  logic [stam_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [stam_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  stam_pkg::item_t               cur_item  = '0;
  logic                          out_stall = 1'b0;

  // Block outputs
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [stam_pkg::CmdW-1:0]   command_now_o;
  logic [stam_pkg::DriveW-1:0] drive_millivolts_o;
  logic [1:0]                  fault_code_o;
  logic                        feedback_ok_o;
  logic                        ready_res_o;

  // Stimulus and expectation stores
  stam_pkg::item_t   pending_events[$];
  stam_pkg::result_t expected_results[$];
  int      events_accepted = 0;
  int      mismatches      = 0;
  bit      in_took         = 1'b0;
  bit      calm            = 1'b0;
  int      holdoff_left    = 0;
  bit      holdoff_done    = 1'b0;
  logic [stam_pkg::TimeW-1:0] gen_ms = '0;

  // Predictor state and its copy of the registers
  stam_pkg::cfg_t model_cfg = '{min_command: stam_pkg::MinCommandRst,
                                max_command: stam_pkg::MaxCommandRst,
                                step_size: stam_pkg::StepSizeRst,
                                track_tolerance: stam_pkg::TrackTolRst,
                                settle_time_ms: stam_pkg::SettleTimeRst,
                                warm_is_high: 1'b1,
                                feedback_required: 1'b0};
  logic                       mdl_ready     = 1'b0;
  logic [stam_pkg::CmdW-1:0]  mdl_cmd       = '0;
  logic                       mdl_fb_usable = 1'b0;
  stam_pkg::fault_e           mdl_fault     = stam_pkg::FAULT_CLEAR;
  logic [stam_pkg::TimeW-1:0] mdl_change_ms = '0;

  stepped_actuator_tracking_monitor_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .req_type_i         (cur_item.req_type),
    .time_ms_i          (cur_item.time_ms),
    .start_command_i    (cur_item.start_command),
    .valve_decision_i   (cur_item.valve_decision),
    .feedback_value_i   (cur_item.feedback_value),
    .feedback_present_i (cur_item.feedback_present),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .command_now_o      (command_now_o),
    .drive_millivolts_o (drive_millivolts_o),
    .fault_code_o       (fault_code_o),
    .feedback_ok_o      (feedback_ok_o),
    .ready_res_o        (ready_res_o)
  );

  always #5 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic logic cfg_valid(stam_pkg::cfg_t c);
    if (c.min_command >= c.max_command || c.max_command > stam_pkg::CmdLimit) return 1'b0;
    if (c.step_size == '0 || c.step_size > c.max_command - c.min_command) return 1'b0;
    if (c.track_tolerance > stam_pkg::CmdLimit) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [stam_pkg::CmdW-1:0] clamp_to_limits(int v);
    if (v < int'(model_cfg.min_command)) return model_cfg.min_command;
    if (v > int'(model_cfg.max_command)) return model_cfg.max_command;
    return stam_pkg::CmdW'(v);
  endfunction

  // Advance the valve state by one event and return the result it shows
  task automatic predict_valve_event(input stam_pkg::item_t it,
                                     output stam_pkg::result_t r);
    logic                       ok;
    int                         stepped;
    int                         delta;
    logic [stam_pkg::CmdW-1:0]  clamped;
    logic [stam_pkg::CmdW-1:0]  gap;
    logic [stam_pkg::TimeW-1:0] since;
    ok = cfg_valid(model_cfg);
    if (it.req_type == stam_pkg::REQ_INIT) begin
      mdl_ready     = 1'b1;
      mdl_fb_usable = 1'b0;
      mdl_change_ms = it.time_ms;
      if (!ok) begin
        mdl_cmd   = '0;
        mdl_fault = stam_pkg::FAULT_CONFIG;
      end else begin
        mdl_cmd   = clamp_to_limits(int'(it.start_command));
        mdl_fault = model_cfg.feedback_required ? stam_pkg::FAULT_FEEDBACK
                                                : stam_pkg::FAULT_CLEAR;
      end
    end else if (mdl_ready) begin
      if (!ok || (it.req_type == stam_pkg::REQ_DECISION &&
                  it.valve_decision == stam_pkg::DEC_INVALID)) begin
        mdl_fault = stam_pkg::FAULT_CONFIG;
      end else if (it.req_type == stam_pkg::REQ_FORCE_WARM) begin
        mdl_cmd = model_cfg.warm_is_high ? model_cfg.max_command : model_cfg.min_command;
        mdl_change_ms = it.time_ms;
        mdl_fault = (!mdl_fb_usable && model_cfg.feedback_required) ?
                    stam_pkg::FAULT_FEEDBACK : stam_pkg::FAULT_CLEAR;
      end else if (it.req_type == stam_pkg::REQ_DECISION) begin
        // Step toward warm or cool, then clamp; a real change restarts settling
        stepped = int'(mdl_cmd);
        delta   = model_cfg.warm_is_high ? int'(model_cfg.step_size) :
                                           -int'(model_cfg.step_size);
        if (it.valve_decision == stam_pkg::DEC_WARMER) stepped += delta;
        else if (it.valve_decision == stam_pkg::DEC_COOLER) stepped -= delta;
        clamped = clamp_to_limits(stepped);
        if (clamped != mdl_cmd) begin
          mdl_cmd       = clamped;
          mdl_change_ms = it.time_ms;
        end
        if (mdl_fault == stam_pkg::FAULT_TRACKING) mdl_fault = stam_pkg::FAULT_TRACKING;
        else if (!mdl_fb_usable && model_cfg.feedback_required)
          mdl_fault = stam_pkg::FAULT_FEEDBACK;
        else mdl_fault = stam_pkg::FAULT_CLEAR;
      end else begin
        // Feedback sample: usable only when present and within the limits
        if (!it.feedback_present || it.feedback_value < model_cfg.min_command ||
            it.feedback_value > model_cfg.max_command) begin
          mdl_fb_usable = 1'b0;
          mdl_fault = model_cfg.feedback_required ? stam_pkg::FAULT_FEEDBACK
                                                  : stam_pkg::FAULT_CLEAR;
        end else begin
          mdl_fb_usable = 1'b1;
          gap   = (it.feedback_value > mdl_cmd) ? it.feedback_value - mdl_cmd :
                                                  mdl_cmd - it.feedback_value;
          since = it.time_ms - mdl_change_ms;
          mdl_fault = (since >= model_cfg.settle_time_ms &&
                       gap > model_cfg.track_tolerance) ? stam_pkg::FAULT_TRACKING
                                                        : stam_pkg::FAULT_CLEAR;
        end
      end
    end
    r.command_now      = mdl_cmd;
    r.drive_millivolts = stam_pkg::DriveW'(mdl_cmd) * stam_pkg::DriveW'(MvPerTenth);
    r.fault_code       = mdl_fault;
    r.feedback_ok      = mdl_fb_usable;
    r.ready_res        = mdl_ready;
  endtask

  // Offer queued transactions; hold each one until it is taken
  always @(negedge clk_i) begin : drive_events
    bit give;
    if (rst_n && (in_took || !in_valid)) begin
      give = pending_events.size() != 0 && (calm || $urandom_range(99) >= IdlePct);
      if (give) begin
        cur_item <= pending_events.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the output at random, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!holdoff_done && events_accepted >= HoldoffAt) begin
      holdoff_left = HoldoffLen;
      holdoff_done = 1'b1;
    end
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  // Predict on accepted inputs and check accepted results
  always @(posedge clk_i) begin : watch_channels
    stam_pkg::result_t want;
    in_took = rst_n && in_valid && !in_stall_o;
    if (in_took) begin
      predict_valve_event(cur_item, want);
      expected_results.push_back(want);
      events_accepted++;
    end
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, command", command_now_o, -1);
      end else begin
        want = expected_results.pop_front();
        if (command_now_o !== want.command_now)
          report_mismatch("command_now", command_now_o, want.command_now);
        if (drive_millivolts_o !== want.drive_millivolts)
          report_mismatch("drive_millivolts", drive_millivolts_o, want.drive_millivolts);
        if (fault_code_o !== want.fault_code)
          report_mismatch("fault_code", fault_code_o, want.fault_code);
        if (feedback_ok_o !== want.feedback_ok)
          report_mismatch("feedback_ok", feedback_ok_o, want.feedback_ok);
        if (ready_res_o !== want.ready_res)
          report_mismatch("ready_res", ready_res_o, want.ready_res);
      end
    end
  end

  task automatic add_event(stam_pkg::req_e req, logic [stam_pkg::TimeW-1:0] ms, int start,
                           stam_pkg::dec_e dec, int fb, bit present);
    stam_pkg::item_t it;
    it.req_type         = req;
    it.time_ms          = ms;
    it.start_command    = stam_pkg::CmdW'(start);
    it.valve_decision   = dec;
    it.feedback_value   = stam_pkg::CmdW'(fb);
    it.feedback_present = present;
    pending_events.push_back(it);
  endtask

  // Mostly initialized sequences of decisions and feedback with moving time
  task automatic queue_random_events(int count);
    stam_pkg::item_t it;
    int              roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 3) gen_ms = $urandom();
      else if (roll < 5) gen_ms = 32'hFFFF_FFFF - $urandom_range(2000);
      else gen_ms = gen_ms + $urandom_range(3000);
      it.time_ms = gen_ms;

      roll = $urandom_range(99);
      if (n == 0) it.req_type = (roll < 70) ? stam_pkg::REQ_INIT : stam_pkg::REQ_DECISION;
      else if (roll < 6) it.req_type = stam_pkg::REQ_INIT;
      else if (roll < 15) it.req_type = stam_pkg::REQ_FORCE_WARM;
      else if (roll < 58) it.req_type = stam_pkg::REQ_DECISION;
      else it.req_type = stam_pkg::REQ_FEEDBACK;

      it.valve_decision = ($urandom_range(99) < 8) ? stam_pkg::DEC_INVALID :
                          stam_pkg::dec_e'($urandom_range(2));
      if (model_cfg.min_command <= model_cfg.max_command && $urandom_range(99) < 80)
        it.feedback_value = stam_pkg::CmdW'($urandom_range(model_cfg.max_command,
                                                           model_cfg.min_command));
      else
        it.feedback_value = stam_pkg::CmdW'($urandom_range(1023));
      it.feedback_present = $urandom_range(99) < 90;
      it.start_command    = stam_pkg::CmdW'($urandom_range(1023));
      pending_events.push_back(it);
    end
  endtask

  // Wait until all offered transactions are taken and every result has come
  task automatic wait_quiet();
    int                waited;
    stam_pkg::result_t lost;
    waited = 0;
    while (pending_events.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    while (expected_results.size() != 0) begin
      lost = expected_results.pop_front();
      report_mismatch("missing result, command", -1, lost.command_now);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [stam_pkg::CfgIdxW-1:0] idx,
                           logic [stam_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  // Write every register, with junk in the unused upper bits
  task automatic load_config(stam_pkg::cfg_t c);
    write_reg(stam_pkg::CFG_MIN_COMMAND,  {22'($urandom()), c.min_command});
    write_reg(stam_pkg::CFG_MAX_COMMAND,  {22'($urandom()), c.max_command});
    write_reg(stam_pkg::CFG_STEP_SIZE,    {22'($urandom()), c.step_size});
    write_reg(stam_pkg::CFG_TRACK_TOL,    {22'($urandom()), c.track_tolerance});
    write_reg(stam_pkg::CFG_SETTLE_TIME,  c.settle_time_ms);
    write_reg(stam_pkg::CFG_WARM_IS_HIGH, {31'($urandom()), c.warm_is_high});
    write_reg(stam_pkg::CFG_FB_REQUIRED,  {31'($urandom()), c.feedback_required});
    write_reg(CfgIdxUnused,               $urandom());
    @(negedge clk_i);
    cfg_we <= 1'b0;
    model_cfg = c;
  endtask

  function automatic stam_pkg::cfg_t make_cfg(int lo, int hi, int step, int tol,
                                              logic [stam_pkg::TimeW-1:0] settle,
                                              bit warm_high, bit fb_req);
    stam_pkg::cfg_t c;
    c.min_command       = stam_pkg::CmdW'(lo);
    c.max_command       = stam_pkg::CmdW'(hi);
    c.step_size         = stam_pkg::CmdW'(step);
    c.track_tolerance   = stam_pkg::CmdW'(tol);
    c.settle_time_ms    = settle;
    c.warm_is_high      = warm_high;
    c.feedback_required = fb_req;
    return c;
  endfunction

  initial begin : run_phases
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed: ignored events before init, clamps, tolerance and settle edges
    add_event(stam_pkg::REQ_DECISION,   32'd10,  0,    stam_pkg::DEC_WARMER,  0,    1'b1);
    add_event(stam_pkg::REQ_FEEDBACK,   32'd20,  0,    stam_pkg::DEC_HOLD,    500,  1'b1);
    add_event(stam_pkg::REQ_FORCE_WARM, 32'd30,  0,    stam_pkg::DEC_HOLD,    0,    1'b0);
    add_event(stam_pkg::REQ_INIT,       32'd100, 1023, stam_pkg::DEC_HOLD,    0,    1'b0);
    add_event(stam_pkg::REQ_DECISION,   32'd150, 0,    stam_pkg::DEC_WARMER,  0,    1'b0);
    add_event(stam_pkg::REQ_DECISION,   32'd200, 0,    stam_pkg::DEC_COOLER,  0,    1'b0);
    add_event(stam_pkg::REQ_DECISION,   32'd210, 0,    stam_pkg::DEC_HOLD,    0,    1'b0);
    add_event(stam_pkg::REQ_DECISION,   32'd220, 0,    stam_pkg::DEC_INVALID, 0,    1'b0);
    add_event(stam_pkg::REQ_FEEDBACK,   32'd230, 0,    stam_pkg::DEC_HOLD,    990,  1'b0);
    add_event(stam_pkg::REQ_FEEDBACK,   32'd240, 0,    stam_pkg::DEC_HOLD,    1001, 1'b1);
    add_event(stam_pkg::REQ_FEEDBACK,   32'd5200, 0,   stam_pkg::DEC_HOLD,    940,  1'b1);
    add_event(stam_pkg::REQ_FEEDBACK,   32'd5199, 0,   stam_pkg::DEC_HOLD,    939,  1'b1);
    add_event(stam_pkg::REQ_FEEDBACK,   32'd5200, 0,   stam_pkg::DEC_HOLD,    939,  1'b1);
    add_event(stam_pkg::REQ_DECISION,   32'd5300, 0,   stam_pkg::DEC_HOLD,    0,    1'b0);
    add_event(stam_pkg::REQ_FEEDBACK,   32'd5400, 0,   stam_pkg::DEC_HOLD,    990,  1'b1);
    add_event(stam_pkg::REQ_FORCE_WARM, 32'd6000, 0,   stam_pkg::DEC_HOLD,    0,    1'b0);
    add_event(stam_pkg::REQ_INIT,     32'hFFFF_FFF0, 0, stam_pkg::DEC_HOLD,   0,    1'b0);
    add_event(stam_pkg::REQ_DECISION, 32'hFFFF_FFF8, 0, stam_pkg::DEC_COOLER, 0,    1'b0);
    add_event(stam_pkg::REQ_DECISION, 32'h0000_0010, 0, stam_pkg::DEC_WARMER, 0,    1'b0);
    add_event(stam_pkg::REQ_FEEDBACK, 32'h0000_1390, 0, stam_pkg::DEC_HOLD,   500,  1'b1);
    add_event(stam_pkg::REQ_FEEDBACK, 32'h0000_1398, 0, stam_pkg::DEC_HOLD,   500,  1'b1);
    add_event(stam_pkg::REQ_INIT,     32'hFFFF_FFFF, 512, stam_pkg::DEC_HOLD, 1023, 1'b1);
    add_event(stam_pkg::REQ_FEEDBACK, 32'hFFFF_FFFF, 0, stam_pkg::DEC_HOLD,   1023, 1'b1);
    wait_quiet();

    // Reset settings; the long output hold-off falls in here
    queue_random_events(250);
    wait_quiet();

    // Full span, one step covers it, zero tolerance and settle, warm is low
    load_config(make_cfg(0, 1000, 1000, 0, 32'd0, 1'b0, 1'b1));
    calm = 1'b1;
    queue_random_events(200);
    wait_quiet();
    calm = 1'b0;

    // Narrow window, widest tolerance, longest settle
    load_config(make_cfg(200, 800, 37, 1000, 32'hFFFF_FFFF, 1'b1, 1'b0));
    queue_random_events(250);
    wait_quiet();

    // Bad settings: empty span, limit above full scale, zero step, big tolerance
    load_config(make_cfg(500, 500, 10, 50, 32'd5000, 1'b1, 1'b0));
    queue_random_events(40);
    wait_quiet();
    load_config(make_cfg(0, 1023, 10, 50, 32'd5000, 1'b1, 1'b1));
    queue_random_events(30);
    wait_quiet();
    load_config(make_cfg(1023, 1000, 0, 1023, 32'd5000, 1'b0, 1'b0));
    queue_random_events(30);
    wait_quiet();

    // Tightest valid window, leaves an old command outside the limits
    load_config(make_cfg(999, 1000, 1, 3, 32'd100, 1'b0, 1'b1));
    queue_random_events(200);
    wait_quiet();

    // Step one more than the span
    load_config(make_cfg(100, 200, 101, 20, 32'd1000, 1'b1, 1'b0));
    queue_random_events(30);
    wait_quiet();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
